// File: rtl/multilevel_bimodal_threshold_core_assert.svh
// Assertion macros used by the top-level RTL.
// Each macro checks a property on the rising edge of clk, disabled during rst.
`ifndef MULTILEVEL_BIMODAL_THRESHOLD_CORE_ASSERT_SVH
`define MULTILEVEL_BIMODAL_THRESHOLD_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define MBT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// The consequent must hold in the cycle after the antecedent.
`define MBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define MBT_ASSERT_SAME(label, ante, cons)
`define MBT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/mbt_pkg.sv
package mbt_pkg;

  // Histogram and table geometry.
  localparam int BINS      = 256;
  localparam int BIN_BITS  = 8;
  localparam int QUOT_BITS = 16;
  localparam int LANES     = 3;

  // Command codes.
  localparam logic [1:0] CMD_COUNT  = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_MAP    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result kinds.
  localparam logic KIND_TABLES = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;
  localparam logic [1:0] REG_OFFSET      = 2'd1;
  localparam logic [1:0] REG_USE_MEDIAN  = 2'd2;

  // Lane sequencer states.
  typedef enum logic [4:0] {
    L_CLEAR, L_IDLE, L_INC, L_EXT, L_PDIV, L_SUM, L_DIVB, L_DIVW, L_MUL, L_ADD,
    L_CMP, L_CUTW, L_BRD, L_BWAIT, L_BLEV, L_BSUM, L_BDIV, L_TFILL, L_HCLR, L_DONE
  } lane_state_t;

  // Configuration as seen by the lanes (level count already clamped to at least 2).
  typedef struct packed {
    logic [7:0]        level_count;
    logic signed [7:0] threshold_offset;
    logic              use_median;
  } cfg_t;

  // Commands from the top level to a lane.
  typedef struct packed {
    logic cnt_go;
    logic fin_go;
    logic ack;
  } lane_ctrl_t;

  // Status from a lane to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

// File: rtl/mbt_ram.sv
module mbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/mbt_div.sv
module mbt_div #(
  parameter int DW = 48,
  parameter int VW = 40
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [DW-1:0]                  dividend,
  input  logic [VW-1:0]                  divisor,
  output logic                           done,
  output logic [mbt_pkg::QUOT_BITS-1:0]  quotient
);

  localparam int QB = mbt_pkg::QUOT_BITS;
  localparam int XW = VW + QB;
  localparam int CW = $clog2(QB);

  logic          run;
  logic [CW-1:0] step;
  logic [XW-1:0] rem;
  logic [XW-1:0] dsh;
  logic          fits;

  // One quotient bit per cycle; the quotient is known to fit in QB bits.
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run      <= 1'b1;
        step     <= CW'(QB - 1);
        rem      <= XW'(dividend);
        dsh      <= XW'(divisor) << (QB - 1);
        quotient <= '0;
      end else if (run) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quotient <= {quotient[QB-2:0], fits};
        dsh      <= dsh >> 1;
        step     <= step - CW'(1);
        if (step == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/mbt_lane.sv
module mbt_lane #(
  parameter int MAX_ITERATIONS = 64,
  parameter int COUNT_BITS     = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  mbt_pkg::lane_ctrl_t ctrl,
  input  mbt_pkg::cfg_t       cfg,
  input  logic [7:0]          pix,
  output mbt_pkg::lane_stat_t stat,
  output logic [7:0]          level_out
);

  localparam int SUM_W  = COUNT_BITS + 16;
  localparam int CNT_W  = COUNT_BITS + 8;
  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
  localparam int QB     = mbt_pkg::QUOT_BITS;

  mbt_pkg::lane_state_t state, state_next;

  // Memory ports.
  logic                  h_we;
  logic [7:0]            h_addr;
  logic [COUNT_BITS-1:0] h_wdata, hq;
  logic                  l_we;
  logic [7:0]            l_addr;
  logic                  c_we;
  logic [7:0]            c_addr;
  logic [7:0]            cq;

  // Sweep address generator with a registered read tag.
  logic       sweep_on;
  logic [7:0] sweep_addr, sweep_last;
  logic       tag_v;
  logic [7:0] tag_addr;
  logic       sweep_done;

  // Threshold iteration.
  logic [7:0]       tt;
  logic [8:0]       t;
  logic [ITER_W-1:0] n;
  logic [15:0]      p;
  logic [7:0]       lo, hi;
  logic             found;
  logic [SUM_W-1:0] sum_lo, sum_hi;
  logic [CNT_W-1:0] cnt_lo, cnt_hi;
  logic [CNT_W-1:0] hprod;
  logic [7:0]       mb, mw, nxt;
  logic [23:0]      prod_w;
  logic [24:0]      prod_b;
  logic [24:0]      prod_sum;
  logic             iter_last;

  // Cut and band values.
  logic [7:0]        tc;
  logic signed [9:0] cut_sum;
  logic [7:0]        cut_val;
  logic [7:0]        a_cut, b_cut, a_val, level;
  logic [8:0]        ab_sum;
  logic [7:0]        fill_start;
  logic              fill_any;
  logic              tt_last;

  // Shared divider.
  logic             div_go, div_done;
  logic [SUM_W-1:0] div_a;
  logic [CNT_W-1:0] div_b;
  logic [QB-1:0]    div_q;

  mbt_ram #(.WIDTH(COUNT_BITS), .DEPTH(mbt_pkg::BINS)) u_hist (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(hq)
  );

  mbt_ram #(.WIDTH(8), .DEPTH(mbt_pkg::BINS)) u_table (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(level), .rdata(level_out)
  );

  mbt_ram #(.WIDTH(8), .DEPTH(mbt_pkg::BINS)) u_cuts (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(cut_val), .rdata(cq)
  );

  mbt_div #(.DW(SUM_W), .VW(CNT_W)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  // Helper values.
  assign sweep_done = !sweep_on && !tag_v;
  assign hprod      = CNT_W'(hq) * CNT_W'(tag_addr);
  assign prod_sum   = {1'b0, prod_w} + prod_b;
  assign iter_last  = (n == ITER_W'(MAX_ITERATIONS - 1));
  assign tt_last    = (tt == cfg.level_count - 8'd1);
  assign tc         = t[8] ? 8'hFF : t[7:0];
  assign cut_sum    = $signed({2'b00, tc})
                    + $signed({{2{cfg.threshold_offset[7]}}, cfg.threshold_offset});
  assign cut_val    = cut_sum[9] ? 8'd0 : (cut_sum[8] ? 8'hFF : cut_sum[7:0]);
  assign a_val      = (tt == 8'd0) ? lo : a_cut;
  assign ab_sum     = {1'b0, a_val} + {1'b0, b_cut};
  assign fill_start = (tt == 8'd0) ? 8'd0 : a_cut + 8'd1;
  assign fill_any   = (tt == 8'd0) || (a_cut != 8'hFF);

  assign stat.busy = (state != mbt_pkg::L_IDLE);
  assign stat.done = (state == mbt_pkg::L_DONE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbt_pkg::L_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    h_we       = 1'b0;
    h_addr     = sweep_addr;
    h_wdata    = '0;
    l_we       = 1'b0;
    l_addr     = sweep_addr;
    c_we       = 1'b0;
    c_addr     = tt;
    case (state)
      mbt_pkg::L_CLEAR, mbt_pkg::L_HCLR: begin
        h_we = 1'b1;
        if (sweep_addr == 8'hFF) begin
          state_next = (state == mbt_pkg::L_CLEAR) ? mbt_pkg::L_IDLE : mbt_pkg::L_DONE;
        end
      end
      mbt_pkg::L_IDLE: begin
        h_addr = pix;
        l_addr = pix;
        if (ctrl.cnt_go) begin
          state_next = mbt_pkg::L_INC;
        end else if (ctrl.fin_go) begin
          state_next = mbt_pkg::L_EXT;
        end
      end
      mbt_pkg::L_INC: begin
        h_we       = 1'b1;
        h_addr     = tag_addr;
        h_wdata    = (&hq) ? hq : hq + COUNT_BITS'(1);
        state_next = mbt_pkg::L_IDLE;
      end
      mbt_pkg::L_EXT: begin
        if (sweep_done) begin
          state_next = mbt_pkg::L_PDIV;
        end
      end
      mbt_pkg::L_PDIV: begin
        if (div_done) begin
          state_next = mbt_pkg::L_SUM;
        end
      end
      mbt_pkg::L_SUM: begin
        if (sweep_done) begin
          if (cnt_lo != '0) begin
            state_next = mbt_pkg::L_DIVB;
          end else if (cnt_hi != '0) begin
            state_next = mbt_pkg::L_DIVW;
          end else begin
            state_next = mbt_pkg::L_CUTW;
          end
        end
      end
      mbt_pkg::L_DIVB: begin
        if (div_done) begin
          state_next = (cnt_hi != '0) ? mbt_pkg::L_DIVW : mbt_pkg::L_CMP;
        end
      end
      mbt_pkg::L_DIVW: begin
        if (div_done) begin
          state_next = (cnt_lo != '0) ? mbt_pkg::L_MUL : mbt_pkg::L_CMP;
        end
      end
      mbt_pkg::L_MUL: state_next = mbt_pkg::L_ADD;
      mbt_pkg::L_ADD: state_next = mbt_pkg::L_CMP;
      mbt_pkg::L_CMP: begin
        if (({1'b0, nxt} == t) || iter_last) begin
          state_next = mbt_pkg::L_CUTW;
        end else begin
          state_next = mbt_pkg::L_SUM;
        end
      end
      mbt_pkg::L_CUTW: begin
        c_we       = 1'b1;
        state_next = tt_last ? mbt_pkg::L_BRD : mbt_pkg::L_PDIV;
      end
      mbt_pkg::L_BRD: begin
        c_addr     = tt + 8'd1;
        state_next = tt_last ? mbt_pkg::L_BLEV : mbt_pkg::L_BWAIT;
      end
      mbt_pkg::L_BWAIT: state_next = mbt_pkg::L_BLEV;
      mbt_pkg::L_BLEV: begin
        if (cfg.use_median) begin
          state_next = (a_val <= b_cut) ? mbt_pkg::L_BSUM : mbt_pkg::L_TFILL;
        end else begin
          state_next = mbt_pkg::L_BDIV;
        end
      end
      mbt_pkg::L_BSUM: begin
        if (sweep_done) begin
          state_next = (cnt_lo != '0) ? mbt_pkg::L_BDIV : mbt_pkg::L_TFILL;
        end
      end
      mbt_pkg::L_BDIV: begin
        if (div_done) begin
          state_next = mbt_pkg::L_TFILL;
        end
      end
      mbt_pkg::L_TFILL: begin
        l_we = sweep_on;
        if (!sweep_on) begin
          state_next = tt_last ? mbt_pkg::L_HCLR : mbt_pkg::L_BRD;
        end
      end
      mbt_pkg::L_DONE: begin
        if (ctrl.ack) begin
          state_next = mbt_pkg::L_IDLE;
        end
      end
      default: state_next = mbt_pkg::L_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_on   <= 1'b0;
      sweep_addr <= 8'd0;
      tag_v      <= 1'b0;
      div_go     <= 1'b0;
    end else begin
      div_go   <= 1'b0;
      tag_v    <= sweep_on && ((state == mbt_pkg::L_EXT) || (state == mbt_pkg::L_SUM)
                  || (state == mbt_pkg::L_BSUM));
      tag_addr <= sweep_addr;
      if (sweep_on) begin
        if (sweep_addr == sweep_last) begin
          sweep_on <= 1'b0;
        end else begin
          sweep_addr <= sweep_addr + 8'd1;
        end
      end
      case (state)
        mbt_pkg::L_CLEAR, mbt_pkg::L_HCLR: begin
          sweep_addr <= sweep_addr + 8'd1;
        end
        mbt_pkg::L_IDLE: begin
          tag_addr <= pix;
          if (ctrl.fin_go && !ctrl.cnt_go) begin
            sweep_on   <= 1'b1;
            sweep_addr <= 8'd0;
            sweep_last <= 8'hFF;
            lo         <= 8'hFF;
            hi         <= 8'd0;
            found      <= 1'b0;
            tt         <= 8'd1;
          end
        end
        mbt_pkg::L_EXT: begin
          // Lowest and highest occupied bins.
          if (tag_v && (hq != '0)) begin
            if (!found) begin
              lo    <= tag_addr;
              found <= 1'b1;
            end
            if (tag_addr != 8'd0) begin
              hi <= tag_addr;
            end
          end
          if (sweep_done) begin
            div_go <= 1'b1;
            div_a  <= SUM_W'({8'd1, 16'd0});
            div_b  <= CNT_W'(cfg.level_count);
          end
        end
        mbt_pkg::L_PDIV: begin
          if (div_done) begin
            p          <= div_q;
            t          <= 9'(({1'b0, div_q} + 17'd128) >> 8);
            n          <= '0;
            sweep_on   <= 1'b1;
            sweep_addr <= 8'd0;
            sweep_last <= 8'hFF;
            sum_lo     <= '0;
            sum_hi     <= '0;
            cnt_lo     <= '0;
            cnt_hi     <= '0;
          end
        end
        mbt_pkg::L_SUM: begin
          // Class sums below and at or above the threshold.
          if (tag_v) begin
            if ({1'b0, tag_addr} < t) begin
              sum_lo <= sum_lo + SUM_W'(hprod);
              cnt_lo <= cnt_lo + CNT_W'(hq);
            end else begin
              sum_hi <= sum_hi + SUM_W'(hprod);
              cnt_hi <= cnt_hi + CNT_W'(hq);
            end
          end
          if (sweep_done) begin
            if (cnt_lo != '0) begin
              div_go <= 1'b1;
              div_a  <= sum_lo;
              div_b  <= cnt_lo;
            end else if (cnt_hi != '0) begin
              div_go <= 1'b1;
              div_a  <= sum_hi;
              div_b  <= cnt_hi;
            end
          end
        end
        mbt_pkg::L_DIVB: begin
          if (div_done) begin
            mb  <= div_q[7:0];
            nxt <= div_q[7:0];
            if (cnt_hi != '0) begin
              div_go <= 1'b1;
              div_a  <= sum_hi;
              div_b  <= cnt_hi;
            end
          end
        end
        mbt_pkg::L_DIVW: begin
          if (div_done) begin
            mw  <= div_q[7:0];
            nxt <= div_q[7:0];
          end
        end
        mbt_pkg::L_MUL: begin
          prod_w <= mw * p;
          prod_b <= mb * (17'h10000 - {1'b0, p});
        end
        mbt_pkg::L_ADD: begin
          nxt <= prod_sum[23:16];
        end
        mbt_pkg::L_CMP: begin
          t <= {1'b0, nxt};
          if (!(({1'b0, nxt} == t) || iter_last)) begin
            n          <= n + ITER_W'(1);
            sweep_on   <= 1'b1;
            sweep_addr <= 8'd0;
            sweep_last <= 8'hFF;
            sum_lo     <= '0;
            sum_hi     <= '0;
            cnt_lo     <= '0;
            cnt_hi     <= '0;
          end
        end
        mbt_pkg::L_CUTW: begin
          if (tt_last) begin
            tt <= 8'd0;
          end else begin
            tt     <= tt + 8'd1;
            div_go <= 1'b1;
            div_a  <= SUM_W'({tt + 8'd1, 16'd0});
            div_b  <= CNT_W'(cfg.level_count);
          end
        end
        mbt_pkg::L_BRD: begin
          if (tt_last) begin
            b_cut <= hi;
          end
        end
        mbt_pkg::L_BWAIT: begin
          b_cut <= cq;
        end
        mbt_pkg::L_BLEV: begin
          if (cfg.use_median) begin
            if (a_val <= b_cut) begin
              sweep_on   <= 1'b1;
              sweep_addr <= a_val;
              sweep_last <= b_cut;
              sum_lo     <= '0;
              cnt_lo     <= '0;
            end else begin
              level      <= ab_sum[8:1];
              sweep_on   <= fill_any;
              sweep_addr <= fill_start;
              sweep_last <= 8'hFF;
            end
          end else begin
            div_go <= 1'b1;
            div_a  <= SUM_W'({8'd0, tt} * 16'd255);
            div_b  <= CNT_W'(cfg.level_count - 8'd1);
          end
        end
        mbt_pkg::L_BSUM: begin
          // Band population and weighted sum.
          if (tag_v) begin
            sum_lo <= sum_lo + SUM_W'(hprod);
            cnt_lo <= cnt_lo + CNT_W'(hq);
          end
          if (sweep_done) begin
            if (cnt_lo != '0) begin
              div_go <= 1'b1;
              div_a  <= sum_lo;
              div_b  <= cnt_lo;
            end else begin
              level      <= ab_sum[8:1];
              sweep_on   <= fill_any;
              sweep_addr <= fill_start;
              sweep_last <= 8'hFF;
            end
          end
        end
        mbt_pkg::L_BDIV: begin
          if (div_done) begin
            level      <= div_q[7:0];
            sweep_on   <= fill_any;
            sweep_addr <= fill_start;
            sweep_last <= 8'hFF;
          end
        end
        mbt_pkg::L_TFILL: begin
          if (!sweep_on) begin
            a_cut      <= b_cut;
            tt         <= tt + 8'd1;
            sweep_addr <= 8'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/multilevel_bimodal_threshold_core.sv
// Multilevel bimodal threshold core. Three channel lanes each own a histogram,
// a cut table and a level table. A count beat (cmd 0) is a read-modify-write
// through the lane's histogram port; a map beat (cmd 2) has its result strobe
// result_valid in the cycle after it is accepted; cmd 3 is accepted and dropped.
// A finish beat (cmd 1) runs the three lanes side by side and ends with a kind 0
// result once all are done; it first sweeps the histogram to find the occupied
// range, then per cut runs a division plus up to MAX_ITERATIONS passes (one
// 256-bin sweep and up to two divisions), then per level a band sweep (median
// mode only), at most one division and up to 256 table writes, and finally
// clears the histogram. After reset busy stays high while the histograms are
// cleared. The receiver cannot stall: each result is valid for exactly one
// cycle. cfg_ready is always high; registers may only be written while idle.
`include "multilevel_bimodal_threshold_core_assert.svh"

module multilevel_bimodal_threshold_core #(
  parameter int MAX_ITERATIONS = 64,
  parameter int COUNT_BITS     = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] alpha_in,
  output logic       result_valid,
  output logic       kind,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic              [7:0] level_count;
  logic signed       [7:0] threshold_offset;
  logic                    use_median;
  mbt_pkg::cfg_t           cfg;
  mbt_pkg::lane_ctrl_t     ctrl;
  mbt_pkg::lane_stat_t     lane_stat [mbt_pkg::LANES];
  logic              [7:0] lane_pix  [mbt_pkg::LANES];
  logic              [7:0] lane_lvl  [mbt_pkg::LANES];
  logic                    accept;
  logic                    all_done;
  logic              [7:0] alpha_r;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count      <= 8'd2;
      threshold_offset <= 8'sd0;
      use_median       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mbt_pkg::REG_LEVEL_COUNT: level_count      <= cfg_data;
        mbt_pkg::REG_OFFSET:      threshold_offset <= $signed(cfg_data);
        mbt_pkg::REG_USE_MEDIAN:  use_median       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.level_count      = (level_count < 8'd2) ? 8'd2 : level_count;
  assign cfg.threshold_offset = threshold_offset;
  assign cfg.use_median       = use_median;

  // Command decode.
  assign busy        = lane_stat[0].busy | lane_stat[1].busy | lane_stat[2].busy;
  assign accept      = start && !busy;
  assign all_done    = lane_stat[0].done & lane_stat[1].done & lane_stat[2].done;
  assign ctrl.cnt_go = accept && (cmd == mbt_pkg::CMD_COUNT);
  assign ctrl.fin_go = accept && (cmd == mbt_pkg::CMD_FINISH);
  assign ctrl.ack    = all_done;

  assign lane_pix[0] = red_in;
  assign lane_pix[1] = green_in;
  assign lane_pix[2] = blue_in;

  // One lane per color channel.
  for (genvar i = 0; i < mbt_pkg::LANES; i++) begin : g_lane
    mbt_lane #(.MAX_ITERATIONS(MAX_ITERATIONS), .COUNT_BITS(COUNT_BITS)) u_lane (
      .clk(clk), .rst(rst), .ctrl(ctrl), .cfg(cfg), .pix(lane_pix[i]),
      .stat(lane_stat[i]), .level_out(lane_lvl[i])
    );
  end

  // Result stage: map results and the finish beat once all lanes are done.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      kind         <= mbt_pkg::KIND_TABLES;
    end else begin
      result_valid <= (accept && (cmd == mbt_pkg::CMD_MAP)) || all_done;
      kind         <= (accept && (cmd == mbt_pkg::CMD_MAP)) ? mbt_pkg::KIND_PIXEL
                                                            : mbt_pkg::KIND_TABLES;
    end
  end

  always_ff @(posedge clk) begin
    alpha_r <= alpha_in;
  end

  assign red_out   = (kind == mbt_pkg::KIND_PIXEL) ? lane_lvl[0] : 8'd0;
  assign green_out = (kind == mbt_pkg::KIND_PIXEL) ? lane_lvl[1] : 8'd0;
  assign blue_out  = (kind == mbt_pkg::KIND_PIXEL) ? lane_lvl[2] : 8'd0;
  assign alpha_out = (kind == mbt_pkg::KIND_PIXEL) ? alpha_r : 8'd0;

  // Checks.
  `MBT_ASSERT_NEXT(a_map_result, accept && (cmd == mbt_pkg::CMD_MAP), result_valid && (kind == mbt_pkg::KIND_PIXEL))
  `MBT_ASSERT_NEXT(a_count_silent, accept && (cmd == mbt_pkg::CMD_COUNT), !result_valid)
  `MBT_ASSERT_NEXT(a_finish_busy, accept && (cmd == mbt_pkg::CMD_FINISH), busy)
  `MBT_ASSERT_SAME(a_tables_idle, result_valid && (kind == mbt_pkg::KIND_TABLES), !busy)

endmodule
